[sv/sliding_window_sigma_outlier_filter_assert.svh]
// assertion shorthands shared by the filter rtl
// both expect clk and rst_n in scope
`ifndef SLIDING_WINDOW_SIGMA_OUTLIER_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_SIGMA_OUTLIER_FILTER_ASSERT_SVH

// same-cycle implication
`define SWSOF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWSOF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/swsof_pkg.sv]
`default_nettype none

package swsof_pkg;

  localparam int MAX_HALF    = 15;
  localparam int SAMPLE_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int HW_BITS     = 4;
  localparam int HALF_RESET  = 2;

  localparam int RING_DEPTH = 2 * MAX_HALF + 1;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int K_W        = $clog2(RING_DEPTH + 1);
  localparam int SEEN_W     = 6;
  localparam int SEEN_MAX   = 2 ** SEEN_W - 1;
  localparam int SUM_W      = SAMPLE_BITS + K_W;
  localparam int SQ_W       = 2 * SAMPLE_BITS;
  localparam int QSUM_W     = 2 * SAMPLE_BITS + K_W - 1;
  localparam int DEV_W      = SUM_W + 1;
  localparam int CMP_W      = 2 * DEV_W + 1;
  localparam int KQ_W       = K_W + QSUM_W;
  localparam int ENTRY_W    = SAMPLE_BITS + TIME_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TIME_BITS-1:0]          stamp_t;
  typedef logic [PTR_W-1:0]              ptr_t;
  typedef logic [K_W-1:0]                kcount_t;
  typedef logic [SEEN_W-1:0]             seen_t;
  typedef logic [HW_BITS-1:0]            half_t;
  typedef logic [ENTRY_W-1:0]            entry_t;
  typedef logic signed [SUM_W-1:0]       sumw_t;
  typedef logic signed [SQ_W-1:0]        sqw_t;
  typedef logic [QSUM_W-1:0]             qsum_t;
  typedef logic signed [DEV_W-1:0]       devw_t;
  typedef logic signed [CMP_W-1:0]       cmpw_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_QSUM,
    ST_MULT,
    ST_EMIT,
    ST_FL_RD,
    ST_FL_OUT,
    ST_SW_RD,
    ST_SW_SQ,
    ST_SW_ACC
  } state_t;

  // ring port requests from the sequencer
  typedef struct packed {
    logic   wr_en;
    ptr_t   wr_addr;
    entry_t wr_data;
    logic   rd_a_en;
    ptr_t   rd_a_addr;
    logic   rd_b_en;
    ptr_t   rd_b_addr;
  } ring_req_t;

  function automatic half_t cap_half(half_t raw);
    if (int'(raw) > MAX_HALF) begin
      return half_t'(MAX_HALF);
    end
    return raw;
  endfunction

  function automatic kcount_t win_len(half_t h);
    return kcount_t'(2 * int'(h) + 1);
  endfunction

  // slot that lies off places before slot p
  function automatic ptr_t ring_back(ptr_t p, kcount_t off);
    int s;
    s = int'(p) + RING_DEPTH - int'(off);
    if (s >= RING_DEPTH) begin
      s = s - RING_DEPTH;
    end
    return ptr_t'(s);
  endfunction

  function automatic ptr_t ring_next(ptr_t p);
    if (int'(p) == RING_DEPTH - 1) begin
      return '0;
    end
    return ptr_t'(int'(p) + 1);
  endfunction

endpackage

`default_nettype wire

[sv/swsof_if.sv]
`default_nettype none

interface swsof_in_if import swsof_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample_value;
  stamp_t  sample_time;
  logic    end_of_stream;

  modport source (output valid, output sample_value, output sample_time,
                  output end_of_stream, input ready);
  modport sink (input valid, input sample_value, input sample_time,
                input end_of_stream, output ready);
endinterface

interface swsof_out_if import swsof_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t out_value;
  stamp_t  out_time;
  logic    keep;
  logic    last_out;

  modport source (output valid, output out_value, output out_time,
                  output keep, output last_out, input ready);
  modport sink (input valid, input out_value, input out_time,
                input keep, input last_out, output ready);
endinterface

`default_nettype wire

[sv/sliding_window_sigma_outlier_filter.sv]
// channel   dir  word                                          handshake
// in_chan   in   sample_value, sample_time, end_of_stream      valid/ready
// out_chan  out  out_value, out_time, keep, last_out           valid/ready
// cfg       in   cfg_wdata = half_width                        cfg_we, no wait
//
// a sample steps through accept, ring read, sum update, squaring, verdict; the next is taken after the verdict
// end of stream adds a ring read, then an output, for each flushed sample
// a half_width write starts a resum of the window over min(seen, 2h+1) samples from the ring
// reset (rst_n low, synchronous) clears sums, counters and pointer, half_width = 2
// a stalled result holds the block only when a second result is ready to load
`default_nettype none

module sliding_window_sigma_outlier_filter import swsof_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  swsof_in_if.sink               in_chan,
  swsof_out_if.source            out_chan,
  input  wire logic              cfg_we,
  input  wire logic [HW_BITS-1:0] cfg_wdata
);

`include "sliding_window_sigma_outlier_filter_assert.svh"

  // control state
  state_t  state_r, state_nxt;
  half_t   hw_r;
  ptr_t    ptr_r;
  seen_t   seen_r;
  sumw_t   sum_r;
  qsum_t   qsum_r;
  kcount_t fl_cnt_r;
  kcount_t sw_d_r;
  logic    out_valid_r;

  // datapath registers
  sample_t                    nv_r;
  stamp_t                     nt_r;
  logic                       eos_r;
  sample_t                    cen_v_r;
  stamp_t                     cen_t_r;
  sqw_t                       sq_new_r;
  sqw_t                       sq_old_r;
  sample_t                    sw_v_r;
  sumw_t                      kx_r;
  devw_t                      dev_r;
  logic signed [2*DEV_W-1:0]  lhs_r;
  logic signed [2*SUM_W-1:0]  ss_r;
  logic [KQ_W-1:0]            kq_r;
  sample_t                    out_value_r;
  stamp_t                     out_time_r;
  logic                       out_keep_r;
  logic                       out_last_r;

  // ring
  ring_req_t ring_req;
  entry_t    rd_a_data, rd_b_data;
  sample_t   rd_a_v, rd_b_v;
  stamp_t    rd_a_t, rd_b_t;

  // combinational
  half_t           h;
  kcount_t         k;
  logic signed [K_W:0] k_s;
  logic            in_ready_c, in_fire, slot_free;
  logic            drop_old, emit_norm, full_win;
  kcount_t         fl_len, sweep_len;
  sample_t         old_v, cen_v_c;
  stamp_t          cen_t_c;
  sqw_t            sq_new_c, sq_old_c, sq_sw_c;
  sumw_t           kx_c;
  cmpw_t           rhs_c;
  logic            verdict_keep;
  logic            out_load, finish;
  sample_t         out_value_nxt;
  stamp_t          out_time_nxt;
  logic            out_keep_nxt, out_last_nxt;

  swsof_ring u_ring (
    .clk       (clk),
    .req       (ring_req),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  assign rd_a_v = sample_t'(rd_a_data[ENTRY_W-1 -: SAMPLE_BITS]);
  assign rd_a_t = rd_a_data[TIME_BITS-1:0];
  assign rd_b_v = sample_t'(rd_b_data[ENTRY_W-1 -: SAMPLE_BITS]);
  assign rd_b_t = rd_b_data[TIME_BITS-1:0];

  assign h   = cap_half(hw_r);
  assign k   = win_len(h);
  assign k_s = {1'b0, k};

  assign slot_free = !out_valid_r || out_chan.ready;

  // seen_r already counts the current sample once it is accepted
  assign drop_old  = int'(seen_r) > int'(k);
  assign emit_norm = int'(seen_r) > int'(h);
  assign full_win  = int'(seen_r) >= int'(k);
  assign fl_len    = (int'(seen_r) < int'(h)) ? kcount_t'(seen_r) : kcount_t'(h);
  assign sweep_len = (int'(seen_r) < int'(k)) ? kcount_t'(seen_r) : k;

  // sum update stage: sample leaving the window and the centre sample
  assign old_v    = drop_old ? rd_a_v : '0;
  assign cen_v_c  = (h == '0) ? nv_r : rd_b_v;
  assign cen_t_c  = (h == '0) ? nt_r : rd_b_t;
  assign sq_new_c = nv_r * nv_r;
  assign sq_old_c = old_v * old_v;
  assign sq_sw_c  = rd_a_v * rd_a_v;
  assign kx_c     = k_s * cen_v_c;

  // (k*x - S)^2 against k*Q - S^2, negative right side taken as zero
  assign rhs_c        = cmpw_t'($signed({1'b0, kq_r})) - cmpw_t'(ss_r);
  assign verdict_keep = rhs_c[CMP_W-1] ? (lhs_r == '0) : (cmpw_t'(lhs_r) <= rhs_c);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:  state_nxt = ST_QSUM;
      ST_QSUM: state_nxt = ST_MULT;
      ST_MULT: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!emit_norm || slot_free) begin
          state_nxt = (eos_r && fl_len != '0) ? ST_FL_RD : ST_IDLE;
        end
      end
      ST_FL_RD: state_nxt = ST_FL_OUT;
      ST_FL_OUT: begin
        if (slot_free) begin
          state_nxt = (fl_cnt_r == kcount_t'(1)) ? ST_IDLE : ST_FL_RD;
        end
      end
      ST_SW_RD: state_nxt = (sw_d_r == sweep_len) ? ST_IDLE : ST_SW_SQ;
      ST_SW_SQ: state_nxt = ST_SW_ACC;
      ST_SW_ACC: state_nxt = ST_SW_RD;
      default: state_nxt = ST_IDLE;
    endcase
    // new half width: resum the window from the ring
    if (cfg_we) begin
      state_nxt = ST_SW_RD;
    end
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_c       = (state_r == ST_IDLE) && !cfg_we;
    in_fire          = in_chan.valid && in_ready_c;
    ring_req         = '0;
    ring_req.wr_addr = ptr_r;
    ring_req.wr_data = {in_chan.sample_value, in_chan.sample_time};
    out_load         = 1'b0;
    finish           = 1'b0;
    out_value_nxt    = cen_v_r;
    out_time_nxt     = cen_t_r;
    out_keep_nxt     = 1'b1;
    out_last_nxt     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // write the new sample, fetch the leaving one and the centre one
        ring_req.wr_en     = in_fire;
        ring_req.rd_a_en   = in_fire;
        ring_req.rd_a_addr = ring_back(ptr_r, k);
        ring_req.rd_b_en   = in_fire;
        ring_req.rd_b_addr = ring_back(ptr_r, kcount_t'(h));
      end
      ST_EMIT: begin
        out_load     = emit_norm && slot_free;
        out_keep_nxt = full_win ? verdict_keep : 1'b1;
        out_last_nxt = eos_r && fl_len == '0;
        finish       = (!emit_norm || slot_free) && eos_r && fl_len == '0;
      end
      ST_FL_RD: begin
        ring_req.rd_a_en   = 1'b1;
        ring_req.rd_a_addr = ring_back(ptr_r, fl_cnt_r);
      end
      ST_FL_OUT: begin
        out_load      = slot_free;
        out_value_nxt = rd_a_v;
        out_time_nxt  = rd_a_t;
        out_last_nxt  = fl_cnt_r == kcount_t'(1);
        finish        = slot_free && fl_cnt_r == kcount_t'(1);
      end
      ST_SW_RD: begin
        ring_req.rd_a_en   = sw_d_r != sweep_len;
        ring_req.rd_a_addr = ring_back(ptr_r, kcount_t'(sw_d_r + 1'b1));
      end
      default: begin
      end
    endcase
  end

  assign in_chan.ready      = in_ready_c;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_value = out_value_r;
  assign out_chan.out_time  = out_time_r;
  assign out_chan.keep      = out_keep_r;
  assign out_chan.last_out  = out_last_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hw_r        <= half_t'(HALF_RESET);
      ptr_r       <= '0;
      seen_r      <= '0;
      sum_r       <= '0;
      qsum_r      <= '0;
      fl_cnt_r    <= '0;
      sw_d_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        ptr_r  <= ring_next(ptr_r);
        seen_r <= (seen_r == seen_t'(SEEN_MAX)) ? seen_r : seen_r + 1'b1;
      end
      case (state_r)
        ST_UPD: begin
          sum_r <= sum_r + sumw_t'(nv_r) - sumw_t'(old_v);
        end
        ST_QSUM: begin
          qsum_r <= qsum_r + qsum_t'($unsigned(sq_new_r)) - qsum_t'($unsigned(sq_old_r));
        end
        ST_EMIT: begin
          if (state_nxt == ST_FL_RD) begin
            fl_cnt_r <= fl_len;
          end
        end
        ST_FL_OUT: begin
          if (slot_free) begin
            fl_cnt_r <= fl_cnt_r - 1'b1;
          end
        end
        ST_SW_ACC: begin
          sum_r  <= sum_r + sumw_t'(sw_v_r);
          qsum_r <= qsum_r + qsum_t'($unsigned(sq_new_r));
          sw_d_r <= sw_d_r + 1'b1;
        end
        default: begin
        end
      endcase
      // stream closed: next sample starts a fresh window
      if (finish) begin
        ptr_r  <= '0;
        seen_r <= '0;
        sum_r  <= '0;
        qsum_r <= '0;
      end
      if (cfg_we) begin
        hw_r   <= cfg_wdata;
        sum_r  <= '0;
        qsum_r <= '0;
        sw_d_r <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      nv_r  <= in_chan.sample_value;
      nt_r  <= in_chan.sample_time;
      eos_r <= in_chan.end_of_stream;
    end
    case (state_r)
      ST_UPD: begin
        cen_v_r  <= cen_v_c;
        cen_t_r  <= cen_t_c;
        sq_new_r <= sq_new_c;
        sq_old_r <= sq_old_c;
        kx_r     <= kx_c;
      end
      ST_QSUM: begin
        dev_r <= devw_t'(kx_r) - devw_t'(sum_r);
      end
      ST_MULT: begin
        lhs_r <= dev_r * dev_r;
        ss_r  <= sum_r * sum_r;
        kq_r  <= k * qsum_r;
      end
      ST_SW_SQ: begin
        sw_v_r   <= rd_a_v;
        sq_new_r <= sq_sw_c;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_value_r <= out_value_nxt;
      out_time_r  <= out_time_nxt;
      out_keep_r  <= out_keep_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  `SWSOF_ASSERT_NOW(a_no_overwrite, out_load, !out_valid_r || out_chan.ready, "result overwritten")
  `SWSOF_ASSERT_NEXT(a_stream_closed, out_load && out_last_nxt, seen_r == '0 && ptr_r == '0, "stream not closed")
  `SWSOF_ASSERT_NOW(a_flush_count, state_r == ST_FL_RD || state_r == ST_FL_OUT, fl_cnt_r != '0, "empty flush")
  `SWSOF_ASSERT_NEXT(a_fire_update, in_fire, state_r == ST_UPD, "accepted word not processed")

endmodule

`default_nettype wire

[sv/swsof_ring.sv]
`default_nettype none

// sample ring: one write port, two registered read ports, old data on collision
module swsof_ring import swsof_pkg::*; (
  input  wire logic      clk,
  input  wire ring_req_t req,
  output entry_t         rd_a_data,
  output entry_t         rd_b_data
);

  entry_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_a_en) begin
      rd_a_data <= mem[req.rd_a_addr];
    end
    if (req.rd_b_en) begin
      rd_b_data <= mem[req.rd_b_addr];
    end
  end

endmodule

`default_nettype wire

[bench/verdict_monitor.sv]
`default_nettype none

module verdict_monitor import swsof_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  swsof_in_if        in_mon,
  swsof_out_if       out_mon,
  input  wire logic  cfg_we,
  input  wire half_t cfg_wdata,
  output int         failures,
  output int         pending
);

  typedef struct {
    sample_t value;
    stamp_t  stamp;
    logic    keep;
    logic    last;
  } verdict_t;

  sample_t  value_ring [RING_DEPTH];
  stamp_t   time_ring [RING_DEPTH];
  int       wr_slot;
  int       seen;
  half_t    cur_half;
  verdict_t verdicts_due [$];
  int       fail_total = 0;

  assign failures = fail_total;

  // slot of the sample that lies back places behind the newest one
  function automatic int back_slot(int back);
    return (wr_slot + 2 * RING_DEPTH - 1 - back) % RING_DEPTH;
  endfunction

  // one-sigma test on the centred window of 2h+1 samples
  function automatic logic window_keep(int h);
    longint s;
    longint q;
    longint x;
    longint dev;
    longint rhs;
    longint v;
    int     k;
    k = 2 * h + 1;
    s = 0;
    q = 0;
    for (int d = 0; d < k; d++) begin
      v = longint'(value_ring[back_slot(d)]);
      s += v;
      q += v * v;
    end
    x = longint'(value_ring[back_slot(h)]);
    dev = longint'(k) * x - s;
    rhs = longint'(k) * q - s * s;
    if (rhs < 0) begin
      rhs = 0;
    end
    return (dev * dev > rhs) ? 1'b0 : 1'b1;
  endfunction

  task automatic predict_verdicts(input sample_t v, input stamp_t t, input logic eos);
    verdict_t batch [$];
    verdict_t r;
    int       h;
    int       n;
    int       cnt;
    h = int'(cur_half);
    if (h > MAX_HALF) begin
      h = MAX_HALF;
    end
    value_ring[wr_slot] = v;
    time_ring[wr_slot] = t;
    wr_slot = (wr_slot + 1) % RING_DEPTH;
    if (seen < SEEN_MAX) begin
      seen++;
    end
    n = seen;
    if (n > h) begin
      r.keep = (n >= 2 * h + 1) ? window_keep(h) : 1'b1;
      r.value = value_ring[back_slot(h)];
      r.stamp = time_ring[back_slot(h)];
      r.last = 1'b0;
      batch.push_back(r);
    end
    if (eos) begin
      // flush held samples oldest first, all kept
      cnt = (n < h) ? n : h;
      while (cnt > 0) begin
        cnt--;
        r.value = value_ring[back_slot(cnt)];
        r.stamp = time_ring[back_slot(cnt)];
        r.keep = 1'b1;
        r.last = 1'b0;
        batch.push_back(r);
      end
      if (batch.size() > 0) begin
        batch[batch.size() - 1].last = 1'b1;
      end
      seen = 0;
      wr_slot = 0;
    end
    foreach (batch[i]) begin
      verdicts_due.push_back(batch[i]);
    end
  endtask

  task automatic check_result();
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      $error("result with none expected: value %0d time %0d", out_mon.out_value,
             out_mon.out_time);
      fail_total++;
      return;
    end
    want = verdicts_due.pop_front();
    if (out_mon.out_value !== want.value) begin
      $error("out_value: expected %0d, actual %0d", want.value, out_mon.out_value);
      fail_total++;
    end
    if (out_mon.out_time !== want.stamp) begin
      $error("out_time: expected %0d, actual %0d", want.stamp, out_mon.out_time);
      fail_total++;
    end
    if (out_mon.keep !== want.keep) begin
      $error("keep: expected %0b, actual %0b", want.keep, out_mon.keep);
      fail_total++;
    end
    if (out_mon.last_out !== want.last) begin
      $error("last_out: expected %0b, actual %0b", want.last, out_mon.last_out);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (value_ring[i]) begin
        value_ring[i] = '0;
        time_ring[i] = '0;
      end
      wr_slot = 0;
      seen = 0;
      cur_half = half_t'(HALF_RESET);
      verdicts_due.delete();
    end else begin
      // results leave before the word of this edge is predicted
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (cfg_we) begin
        cur_half = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_verdicts(in_mon.sample_value, in_mon.sample_time, in_mon.end_of_stream);
      end
    end
    pending <= verdicts_due.size();
  end

endmodule

`default_nettype wire

[bench/sliding_window_sigma_outlier_filter_tb.sv]
`default_nettype none

module sliding_window_sigma_outlier_filter_tb;
  import swsof_pkg::*;

  // random phases stop once this many words, the directed ones included, are in;
  // the last phase may overrun it
  localparam int TARGET_WORDS  = 395;
  // covers a full resum of 31 samples and a word in flight with margin
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 400000;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_we;
  half_t cfg_wdata;
  // no idling on either side while set
  logic  calm = 1'b0;
  int    sent = 0;
  int    failures;
  int    pending;
  int    cycle_count = 0;

  swsof_in_if  in_chan ();
  swsof_out_if out_chan ();

  sliding_window_sigma_outlier_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  verdict_monitor monitor (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending)
  );

  always #6 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sliding_window_sigma_outlier_filter: mismatch");
      $finish;
    end
  end

  // result side stalls about a third of the cycles unless calm
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // one word, with a random gap ahead of it; returns at the accepting edge
  task automatic send_word(input sample_t v, input logic eos);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.sample_value <= v;
    in_chan.sample_time <= $urandom();
    in_chan.end_of_stream <= eos;
    @(posedge clk);
    while (!in_chan.ready) begin
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic send_run(input sample_t vals [$]);
    foreach (vals[i]) begin
      send_word(vals[i], i == vals.size() - 1);
    end
  endtask

  // wait until every verdict is in, then let the block go quiet
  task automatic settle_block();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_half(input int h);
    cfg_we <= 1'b1;
    cfg_wdata <= half_t'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // value shapes: full range, cluster with spikes, flat, tight noise
  function automatic sample_t pick_value(input int mode, input int base);
    int v;
    case (mode)
      0: return sample_t'($urandom());
      1: begin
        if ($urandom_range(0, 9) == 0) begin
          return sample_t'($urandom());
        end
        v = base + int'($urandom_range(0, 200)) - 100;
      end
      2: v = base;
      default: v = base + int'($urandom_range(0, 6)) - 3;
    endcase
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return sample_t'(v);
  endfunction

  // close = 0 leaves the stream open across a half_width change
  task automatic send_stream(input int len, input bit close);
    int mode;
    int base;
    mode = $urandom_range(0, 3);
    base = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < len; i++) begin
      send_word(pick_value(mode, base), close && (i == len - 1));
    end
  endtask

  initial begin
    sample_t run_q [$];
    int      h;
    int      len;
    int      n_streams;
    int      phase;
    bit      close;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_chan.valid <= 1'b0;
    in_chan.sample_value <= '0;
    in_chan.sample_time <= '0;
    in_chan.end_of_stream <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset half_width of two: lone spike in a flat stream
    run_q = {sample_t'(0), sample_t'(0), sample_t'(0), sample_t'(32767),
             sample_t'(0), sample_t'(0), sample_t'(0)};
    send_run(run_q);
    // extremes, stream exactly one window long
    run_q = {sample_t'(-32768), sample_t'(32767), sample_t'(-32768),
             sample_t'(32767), sample_t'(-32768)};
    send_run(run_q);
    // single sample stream, flushed at once
    run_q = {sample_t'(-1)};
    send_run(run_q);
    // stream shorter than the window: all kept
    run_q = {sample_t'(5), sample_t'(5), sample_t'(5)};
    send_run(run_q);
    settle_block();

    // window of three, half_width of one
    write_half(1);
    run_q = {sample_t'(10), sample_t'(10), sample_t'(-30000), sample_t'(10)};
    send_run(run_q);
    settle_block();

    // widest window, short stream
    write_half(MAX_HALF);
    run_q = {sample_t'(32767), sample_t'(-32768), sample_t'(1), sample_t'(-1),
             sample_t'(0)};
    send_run(run_q);
    settle_block();

    // random phases, each under one half_width setting
    phase = 0;
    while (sent < TARGET_WORDS) begin
      if (phase == 0) begin
        h = 1;
      end else if (phase == 1) begin
        h = MAX_HALF;
      end else if (phase == 2) begin
        h = 3;
      end else if ($urandom_range(0, 3) == 0) begin
        h = $urandom_range(8, MAX_HALF);
      end else begin
        h = $urandom_range(1, 7);
      end
      calm = (phase == 3) || (phase == 4);
      write_half(h);
      n_streams = $urandom_range(1, 2);
      for (int s = 0; s < n_streams; s++) begin
        if (phase == 2 && s == 0) begin
          // long enough to saturate the sample counter
          len = 80;
        end else if ($urandom_range(0, 9) < 2) begin
          len = $urandom_range(1, 2 * h);
        end else begin
          len = $urandom_range(2 * h + 1, 2 * h + 24);
        end
        close = !(s == n_streams - 1 && $urandom_range(0, 3) == 0
                  && sent + len < TARGET_WORDS);
        send_stream(len, close);
      end
      settle_block();
      phase++;
    end

    calm = 1'b0;
    settle_block();
    if (failures == 0) begin
      $display("sliding_window_sigma_outlier_filter: match");
    end else begin
      $display("sliding_window_sigma_outlier_filter: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+sv
sv/swsof_pkg.sv
sv/swsof_if.sv
sv/swsof_ring.sv
sv/sliding_window_sigma_outlier_filter.sv
bench/verdict_monitor.sv
bench/sliding_window_sigma_outlier_filter_tb.sv
